// ===== sv/gsst_pkg.sv =====
package gsst_pkg;

  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  localparam int WORD_W  = 32;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int MODE_W  = 2;
  localparam int ACC_W   = 67;
  localparam int MAG_W   = 66;
  localparam int S_DATA_W = 240;

  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_NBR_RD,
    ST_NBR_MUL,
    ST_NBR_ACC,
    ST_DIV_GO,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== sv/gsst_grid_mem.sv =====
module gsst_grid_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [gsst_pkg::WORD_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [gsst_pkg::WORD_W-1:0] rd_data
);

  logic [gsst_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/gsst_div.sv =====
module gsst_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gsst_pkg::MAG_W-1:0]  dividend,
  input  logic                        neg,
  input  logic [gsst_pkg::WORD_W-1:0] divisor,
  output logic                        done,
  output logic [gsst_pkg::WORD_W-1:0] result
);

  logic [gsst_pkg::MAG_W-1:0]  dvd;
  logic [gsst_pkg::WORD_W-1:0] dsr;
  logic [gsst_pkg::WORD_W-1:0] rem;
  logic [gsst_pkg::WORD_W-1:0] quo;
  logic                        sat;
  logic                        sign;
  logic [5:0]                  cnt;
  logic                        busy;

  logic [gsst_pkg::WORD_W:0]   r1;
  logic [gsst_pkg::WORD_W:0]   r2;
  logic [gsst_pkg::WORD_W-1:0] rem_next;
  logic [gsst_pkg::WORD_W-1:0] quo_next;
  logic                        sat_next;
  logic [gsst_pkg::WORD_W-1:0] q1;
  logic                        s1;
  logic [gsst_pkg::WORD_W-1:0] res_next;

  // two restoring steps a cycle, quotient clamps once it no longer fits a signed 32-bit result
  always_comb begin
    r1 = {rem, dvd[gsst_pkg::MAG_W-1]};
    s1 = sat | quo[gsst_pkg::WORD_W-1];
    q1 = {quo[gsst_pkg::WORD_W-2:0], 1'b0};
    if (r1 >= {1'b0, dsr}) begin
      r1 = r1 - {1'b0, dsr};
      q1[0] = 1'b1;
    end
    r2 = {r1[gsst_pkg::WORD_W-1:0], dvd[gsst_pkg::MAG_W-2]};
    sat_next = s1 | q1[gsst_pkg::WORD_W-1];
    quo_next = {q1[gsst_pkg::WORD_W-2:0], 1'b0};
    if (r2 >= {1'b0, dsr}) begin
      r2 = r2 - {1'b0, dsr};
      quo_next[0] = 1'b1;
    end
    rem_next = r2[gsst_pkg::WORD_W-1:0];
    if (sign) begin
      if (sat_next || quo_next[gsst_pkg::WORD_W-1]) begin
        res_next = {1'b1, {(gsst_pkg::WORD_W-1){1'b0}}};
      end else begin
        res_next = -quo_next;
      end
    end else begin
      if (sat_next || quo_next[gsst_pkg::WORD_W-1]) begin
        res_next = {1'b0, {(gsst_pkg::WORD_W-1){1'b1}}};
      end else begin
        res_next = quo_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= 6'd32;
        dvd  <= dividend;
        dsr  <= divisor;
        sign <= neg;
        rem  <= '0;
        quo  <= '0;
        sat  <= 1'b0;
      end else if (busy) begin
        dvd  <= {dvd[gsst_pkg::MAG_W-3:0], 2'b00};
        rem  <= rem_next;
        quo  <= quo_next;
        sat  <= sat_next;
        cnt  <= cnt - 6'd1;
        done <= (cnt == 6'd0);
        if (cnt == 6'd0) begin
          busy   <= 1'b0;
          result <= res_next;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/gauss_seidel_stencil_update.sv =====
// five-point gauss-seidel engine over a signed q15.16 grid held in one synchronous ram
// (GRID_ROWS x GRID_COLS words, address row*GRID_COLS+col). mode 0 writes a word, mode 2
// reads one, mode 1 relaxes cell (row+1, col+1) in place from its four neighbors, the
// per-request coefficients and the source term, dividing by the center coefficient.
// one request is worked at a time. an update runs four neighbor read / multiply /
// accumulate rounds on the single ram read port and one 32x32 multiplier, then the
// radix-4 restoring divider. refused requests (bad position, mode 3, center
// coefficient not positive) answer 0 with the error flag set and leave the grid
// alone. the result sits in an output register, so the next request is taken while it
// waits. grid words come out of reset undefined and must be written before use.
module gauss_seidel_stencil_update #(
  parameter int GRID_ROWS = gsst_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = gsst_pkg::GRID_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // row, col, load_value, west_coeff, east_coeff, south_coeff, north_coeff,
  // source_term, centre_coeff, zero pad
  input  logic [gsst_pkg::S_DATA_W-1:0] s_tdata,
  // mode
  input  logic [gsst_pkg::MODE_W-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // result_value
  output logic [gsst_pkg::WORD_W-1:0]   m_tdata,
  // error_flag
  output logic [0:0]                    m_tuser
);

  localparam int DEPTH  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int W      = gsst_pkg::WORD_W;

  gsst_pkg::state_t state, state_next;

  // latched request
  logic [gsst_pkg::MODE_W-1:0] mode;
  logic [gsst_pkg::ROW_W-1:0]  row;
  logic [gsst_pkg::COL_W-1:0]  col;
  logic [W-1:0]                load_value;
  logic [W-1:0]                coeff [4];
  logic [W-1:0]                source_term;
  logic [W-1:0]                centre_coeff;

  logic [ADDR_W-1:0]           ctr;     // padded center cell address
  logic [1:0]                  idx;     // neighbor round
  logic signed [2*W-1:0]       prod;
  logic signed [gsst_pkg::ACC_W-1:0] acc;
  logic [W-1:0]                res_value;
  logic                        res_err;

  // decode
  logic [31:0]       rc_lin;
  logic [31:0]       ctr_lin;
  logic              pos_ok;
  logic              upd_ok;
  logic [ADDR_W-1:0] addr_rc;

  // ram ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [W-1:0]      wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [W-1:0]      rd_data;

  // divider
  logic              div_start;
  logic              div_done;
  logic [W-1:0]      div_result;
  logic              acc_neg;
  logic [gsst_pkg::ACC_W-1:0] acc_mag;

  logic [ADDR_W-1:0] nbr_addr;
  logic [W-1:0]      cur_coeff;

  always_comb begin
    rc_lin  = 32'(row) * 32'(GRID_COLS) + 32'(col);
    ctr_lin = (32'(row) + 32'd1) * 32'(GRID_COLS) + 32'(col) + 32'd1;
    addr_rc = rc_lin[ADDR_W-1:0];
    pos_ok  = (32'(row) < 32'(GRID_ROWS)) && (32'(col) < 32'(GRID_COLS));
    upd_ok  = (32'(row) + 32'd2 < 32'(GRID_ROWS)) && (32'(col) + 32'd2 < 32'(GRID_COLS))
              && !centre_coeff[W-1] && (centre_coeff != '0);
    acc_neg = acc[gsst_pkg::ACC_W-1];
    acc_mag = acc_neg ? -acc : acc;
    cur_coeff = coeff[idx];
  end

  // west, east, south, north around the center
  always_comb begin
    case (idx)
      2'd0:    nbr_addr = ctr - ADDR_W'(GRID_COLS);
      2'd1:    nbr_addr = ctr + ADDR_W'(GRID_COLS);
      2'd2:    nbr_addr = ctr - ADDR_W'(1);
      default: nbr_addr = ctr + ADDR_W'(1);
    endcase
  end

  // next state and ram / divider controls
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = addr_rc;
    wr_data    = load_value;
    rd_en      = 1'b0;
    rd_addr    = addr_rc;
    div_start  = 1'b0;
    case (state)
      gsst_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = gsst_pkg::ST_DECODE;
        end
      end
      gsst_pkg::ST_DECODE: begin
        if (mode == gsst_pkg::MODE_WRITE && pos_ok) begin
          wr_en      = 1'b1;
          state_next = gsst_pkg::ST_DONE;
        end else if (mode == gsst_pkg::MODE_READ && pos_ok) begin
          rd_en      = 1'b1;
          state_next = gsst_pkg::ST_READ;
        end else if (mode == gsst_pkg::MODE_UPDATE && upd_ok) begin
          state_next = gsst_pkg::ST_NBR_RD;
        end else begin
          state_next = gsst_pkg::ST_DONE;
        end
      end
      gsst_pkg::ST_READ: begin
        state_next = gsst_pkg::ST_DONE;
      end
      gsst_pkg::ST_NBR_RD: begin
        rd_en      = 1'b1;
        rd_addr    = nbr_addr;
        state_next = gsst_pkg::ST_NBR_MUL;
      end
      gsst_pkg::ST_NBR_MUL: begin
        state_next = gsst_pkg::ST_NBR_ACC;
      end
      gsst_pkg::ST_NBR_ACC: begin
        state_next = (idx == 2'd3) ? gsst_pkg::ST_DIV_GO : gsst_pkg::ST_NBR_RD;
      end
      gsst_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = gsst_pkg::ST_DIV;
      end
      gsst_pkg::ST_DIV: begin
        if (div_done) begin
          // write back at once so the next update sees it
          wr_en      = 1'b1;
          wr_addr    = ctr;
          wr_data    = div_result;
          state_next = gsst_pkg::ST_DONE;
        end
      end
      gsst_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = gsst_pkg::ST_IDLE;
        end
      end
      default: state_next = gsst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      gsst_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          mode         <= s_tuser;
          row          <= s_tdata[5:0];
          col          <= s_tdata[11:6];
          load_value   <= s_tdata[43:12];
          coeff[0]     <= s_tdata[75:44];
          coeff[1]     <= s_tdata[107:76];
          coeff[2]     <= s_tdata[139:108];
          coeff[3]     <= s_tdata[171:140];
          source_term  <= s_tdata[203:172];
          centre_coeff <= s_tdata[235:204];
        end
      end
      gsst_pkg::ST_DECODE: begin
        ctr       <= ctr_lin[ADDR_W-1:0];
        idx       <= 2'd0;
        // source term widened from q15.16 to q.32
        acc       <= {{(gsst_pkg::ACC_W-W-16){source_term[W-1]}}, source_term, 16'h0000};
        if (mode == gsst_pkg::MODE_WRITE && pos_ok) begin
          res_value <= load_value;
          res_err   <= 1'b0;
        end else begin
          res_value <= '0;
          res_err   <= 1'b1;
        end
      end
      gsst_pkg::ST_READ: begin
        res_value <= rd_data;
        res_err   <= 1'b0;
      end
      gsst_pkg::ST_NBR_MUL: begin
        prod <= $signed(rd_data) * $signed(cur_coeff);
      end
      gsst_pkg::ST_NBR_ACC: begin
        acc <= acc + {{(gsst_pkg::ACC_W-2*W){prod[2*W-1]}}, prod};
        idx <= idx + 2'd1;
      end
      gsst_pkg::ST_DIV: begin
        if (div_done) begin
          res_value <= div_result;
          res_err   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (state == gsst_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= res_value;
        m_tuser[0] <= res_err;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  gsst_grid_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gsst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag[gsst_pkg::MAG_W-1:0]),
    .neg      (acc_neg),
    .divisor  (centre_coeff),
    .done     (div_done),
    .result   (div_result)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_RANDOM = 900;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ROWS = gsst_pkg::GRID_ROWS_DEF;
  localparam int COLS = gsst_pkg::GRID_COLS_DEF;

  typedef struct packed {
    logic [gsst_pkg::MODE_W-1:0] mode;
    logic [gsst_pkg::ROW_W-1:0]  row;
    logic [gsst_pkg::COL_W-1:0]  col;
    logic [31:0]       load_value;
    logic [31:0]       west;
    logic [31:0]       east;
    logic [31:0]       south;
    logic [31:0]       north;
    logic [31:0]       source;
    logic [31:0]       centre;
  } stencil_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        error;
  } stencil_rsp_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [gsst_pkg::S_DATA_W-1:0] s_tdata;
  logic [gsst_pkg::MODE_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [gsst_pkg::WORD_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  // shadow of the grid and which words hold a defined value
  logic [31:0] grid_shadow [ROWS*COLS];
  bit written [ROWS*COLS];

  stencil_req_t pending_reqs[$];
  stencil_rsp_t expected_rsps[$];
  int errors;
  int cycles;
  bit gen_done;
  int send_gap;
  int recv_gap;
  bit burst_mode;

  gauss_seidel_stencil_update dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly no gap, some short, a few long; none at all in burst stretches
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (burst_mode) return 0;
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic int addr(int r, int c);
    return r * COLS + c;
  endfunction

  // full 64-bit signed product of two q15.16 words
  function automatic logic signed [63:0] mul_ext(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] x;
    logic signed [63:0] y;
    x = signed'(a);
    y = signed'(b);
    return x * y;
  endfunction

  // exact 67-bit weighted sum, divided by the center coefficient, saturated
  function automatic logic [31:0] relax_cell(int r, int c, stencil_req_t q);
    logic signed [gsst_pkg::ACC_W-1:0] acc;
    logic [gsst_pkg::ACC_W-1:0] mag;
    logic [gsst_pkg::ACC_W-1:0] quo;
    logic neg;
    acc = mul_ext(q.west,  grid_shadow[addr(r, c + 1)]);
    acc = acc + mul_ext(q.east,  grid_shadow[addr(r + 2, c + 1)]);
    acc = acc + mul_ext(q.south, grid_shadow[addr(r + 1, c)]);
    acc = acc + mul_ext(q.north, grid_shadow[addr(r + 1, c + 2)]);
    acc = acc + signed'({{19{q.source[31]}}, q.source, 16'h0000});
    neg = acc[gsst_pkg::ACC_W-1];
    mag = neg ? -acc : acc;
    quo = mag / gsst_pkg::ACC_W'(q.centre);
    if (neg) return (quo >= 67'h80000000) ? 32'h80000000 : -quo[31:0];
    return (quo > 67'h7fffffff) ? 32'h7fffffff : quo[31:0];
  endfunction

  function automatic bit update_ok(stencil_req_t q);
    return q.row + 2 < ROWS && q.col + 2 < COLS && !q.centre[31] && q.centre != 0;
  endfunction

  function automatic bit nbrs_written(int r, int c);
    return written[addr(r, c + 1)] && written[addr(r + 2, c + 1)] &&
           written[addr(r + 1, c)] && written[addr(r + 1, c + 2)];
  endfunction

  // queue one request and the response it must produce
  task automatic issue(stencil_req_t q);
    stencil_rsp_t rsp;
    rsp = '{value: 32'h0, error: 1'b1};
    if (q.mode == gsst_pkg::MODE_READ && !written[addr(q.row, q.col)])
      q.mode = gsst_pkg::MODE_WRITE;
    if (q.mode == gsst_pkg::MODE_UPDATE && update_ok(q) && !nbrs_written(q.row, q.col))
      q.mode = gsst_pkg::MODE_WRITE;
    case (q.mode)
      gsst_pkg::MODE_WRITE: begin
        grid_shadow[addr(q.row, q.col)] = q.load_value;
        written[addr(q.row, q.col)] = 1'b1;
        rsp = '{value: q.load_value, error: 1'b0};
      end
      gsst_pkg::MODE_READ: begin
        rsp = '{value: grid_shadow[addr(q.row, q.col)], error: 1'b0};
      end
      gsst_pkg::MODE_UPDATE: begin
        if (update_ok(q)) begin
          rsp = '{value: relax_cell(q.row, q.col, q), error: 1'b0};
          grid_shadow[addr(q.row + 1, q.col + 1)] = rsp.value;
          written[addr(q.row + 1, q.col + 1)] = 1'b1;
        end
      end
      default: ;
    endcase
    pending_reqs.insert(pending_reqs.size(), q);
    expected_rsps.insert(expected_rsps.size(), rsp);
  endtask

  function automatic logic [31:0] pick_coeff();
    logic [31:0] v;
    v = $urandom_range(0, 32'h18000);
    if ($urandom_range(0, 1)) return $urandom();
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic stencil_req_t random_req();
    stencil_req_t q;
    int p;
    int lo;
    p = $urandom_range(0, 99);
    q.mode = (p < 25) ? gsst_pkg::MODE_WRITE : (p < 72) ? gsst_pkg::MODE_UPDATE :
             (p < 95) ? gsst_pkg::MODE_READ : gsst_pkg::MODE_SPARE;
    lo = $urandom_range(0, 1) ? 0 : 56;
    if ($urandom_range(0, 4) == 0) begin
      q.row = $urandom();
      q.col = $urandom();
    end else begin
      q.row = lo + $urandom_range(0, 7);
      q.col = lo + $urandom_range(0, 7);
    end
    q.load_value = $urandom();
    q.west = pick_coeff();
    q.east = pick_coeff();
    q.south = pick_coeff();
    q.north = pick_coeff();
    q.source = pick_coeff();
    p = $urandom_range(0, 99);
    q.centre = (p < 8) ? -$urandom_range(0, 3) : (p < 15) ? $urandom() :
               (p < 20) ? 32'($urandom_range(1, 16)) : $urandom_range(32'h8000, 32'h40000);
    return q;
  endfunction

  initial begin
    stencil_req_t q;
    errors = 0;
    gen_done = 1'b0;
    q = '0;
    // fill two corner windows so reads and updates there have defined words
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) begin
        q = '0;
        q.mode = gsst_pkg::MODE_WRITE;
        q.row = r;
        q.col = c;
        q.load_value = $urandom_range(0, 32'h40000) - 32'h20000;
        issue(q);
        q.row = r + 56;
        q.col = c + 56;
        issue(q);
      end
    // field extremes
    q = '0;
    q.mode = gsst_pkg::MODE_WRITE; q.row = 63; q.col = 63; q.load_value = 32'h7fffffff;
    issue(q);
    q.row = 0; q.col = 0; q.load_value = 32'h80000000; issue(q);
    q.mode = gsst_pkg::MODE_READ; issue(q);
    q.row = 63; q.col = 63; issue(q);
    // saturation both ways: huge positive and negative weighted sums, tiny center
    q.mode = gsst_pkg::MODE_UPDATE; q.row = 0; q.col = 0;
    q.west = 32'h7fffffff; q.east = 32'h7fffffff; q.south = 32'h80000000;
    q.north = 32'h7fffffff; q.source = 32'h7fffffff; q.centre = 32'h1; issue(q);
    q.west = 32'h80000000; q.east = 32'h80000000; q.south = 32'h7fffffff;
    q.north = 32'h80000000; q.source = 32'h80000000; issue(q);
    q.centre = 32'h7fffffff; issue(q);
    // center coefficient zero, negative, most negative
    q.centre = 32'h0; issue(q);
    q.centre = 32'hffffffff; issue(q);
    q.centre = 32'h80000000; issue(q);
    // update positions past the last interior cell, then one inside the window
    q.centre = 32'h10000; q.row = 62; q.col = 1; issue(q);
    q.row = 1; q.col = 62; issue(q);
    q.row = 63; q.col = 63; issue(q);
    q.row = 60; q.col = 60; issue(q);
    // unused mode
    q.mode = gsst_pkg::MODE_SPARE; q.row = 2; q.col = 2; issue(q);
    for (int i = 0; i < NUM_RANDOM; i++) issue(random_req());
    gen_done = 1'b1;
  end

  // request driver
  always @(posedge clk) begin
    stencil_req_t q;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
      burst_mode <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if ($urandom_range(0, 199) == 0) burst_mode <= ~burst_mode;
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        s_tdata <= {4'b0, q.centre, q.source, q.north, q.south, q.east, q.west,
                    q.load_value, q.col, q.row};
        s_tuser <= q.mode;
        s_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // response monitor with random back-pressure
  always @(posedge clk) begin
    stencil_rsp_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with none expected: value %h error %b",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (m_tdata !== want.value) begin
            $display("%0t: result_value expected %h actual %h", $time, want.value, m_tdata);
            errors++;
          end
          if (m_tuser[0] !== want.error) begin
            $display("%0t: error_flag expected %b actual %b", $time, want.error, m_tuser);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) recv_gap <= pick_gap();
      end
    end
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycles <= rst ? 0 : cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (gen_done);
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_tvalid)
      @(posedge clk);
    // drain: a stray extra response would show up here
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gsst_pkg.sv
sv/gsst_grid_mem.sv
sv/gsst_div.sv
sv/gauss_seidel_stencil_update.sv
verif/tb_top.sv
